// File: sv/reliable_header_decoder_top_macros.svh
// Assertion macros used by the header decoder top level.
`ifndef RELIABLE_HEADER_DECODER_TOP_MACROS_SVH
`define RELIABLE_HEADER_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RHD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rhd_pkg.sv
// Shared types and constants for the reliable header decoder.
`default_nettype none

package rhd_pkg;

    localparam int unsigned MAX_VARINT_BYTES = 10;
    localparam int unsigned VCNT_W           = 4;
    localparam int unsigned LEN_W            = 5;

    localparam logic [7:0] SEQ_FLAG    = 8'h04;
    localparam logic [7:0] ACK_FLAG    = 8'h08;
    localparam logic [7:0] CONT_BIT    = 8'h80;
    localparam logic [6:0] PAYLOAD_MSK = 7'h7F;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TRUNC    = 2'd1,
        STATUS_TOO_LONG = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         header_flags;
        logic [31:0]        sequence_res;
        logic [31:0]        acknowledge;
        logic [LEN_W-1:0]   header_length;
    } result_t;

endpackage

`default_nettype wire

// File: sv/rhd_core.sv
// Header decode state and next-state logic; one byte per accepted beat.
`default_nettype none

module rhd_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                beat_fire,
    input  wire logic [7:0]          data_byte,
    input  wire logic                header_start,
    input  wire logic                frame_last,
    input  wire logic                compact_mode,
    output logic                     res_valid,
    output rhd_pkg::result_t         res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIXED,
        PH_SEQ,
        PH_ACK
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [7:0]                      flags_reg, flags_next;
    logic [31:0]                     seq_reg, seq_next;
    logic [31:0]                     ack_reg, ack_next;
    logic [rhd_pkg::VCNT_W-1:0]      vcnt_reg, vcnt_next;
    logic                            ovf_reg, ovf_next;
    logic [rhd_pkg::LEN_W-1:0]       taken_reg, taken_next;
    logic                            cmp_reg, cmp_next;

    logic                            fin;
    rhd_pkg::status_t                fin_status;
    logic [2:0]                      fixed_idx;
    logic [31:0]                     lane_val;
    logic [6:0]                      payload;
    logic [34:0]                     shifted;
    logic [7:0]                      out_flags;

    always_comb begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        seq_next   = seq_reg;
        ack_next   = ack_reg;
        vcnt_next  = vcnt_reg;
        ovf_next   = ovf_reg;
        taken_next = taken_reg;
        cmp_next   = cmp_reg;
        fin        = 1'b0;
        fin_status = rhd_pkg::STATUS_OK;
        fixed_idx  = 3'(taken_reg + 5'd1 - 5'd2);
        lane_val   = 32'(data_byte) << {fixed_idx[1:0], 3'b000};
        payload    = data_byte[6:0] & rhd_pkg::PAYLOAD_MSK;
        shifted    = 35'(payload) << (6'(vcnt_reg[2:0]) * 6'd7);

        if (header_start) begin
            flags_next = data_byte;
            seq_next   = '0;
            ack_next   = '0;
            vcnt_next  = '0;
            ovf_next   = 1'b0;
            taken_next = 5'd1;
            cmp_next   = compact_mode;
            if (!compact_mode) begin
                phase_next = PH_FIXED;
            end else if ((data_byte & rhd_pkg::SEQ_FLAG) != 8'd0) begin
                phase_next = PH_SEQ;
            end else if ((data_byte & rhd_pkg::ACK_FLAG) != 8'd0) begin
                phase_next = PH_ACK;
            end else begin
                fin = 1'b1;   // compact, nothing present
            end
            if (!fin && frame_last) begin
                fin        = 1'b1;
                fin_status = rhd_pkg::STATUS_TRUNC;
            end
        end else if (phase_reg == PH_FIXED) begin
            taken_next = taken_reg + 5'd1;
            if (!fixed_idx[2]) begin
                seq_next = seq_reg | lane_val;
            end else begin
                ack_next = ack_reg | lane_val;
            end
            if (taken_next >= 5'd9) begin
                fin = 1'b1;
            end else if (frame_last) begin
                fin        = 1'b1;
                fin_status = rhd_pkg::STATUS_TRUNC;
            end
        end else if (phase_reg != PH_IDLE) begin
            taken_next = taken_reg + 5'd1;
            if (vcnt_reg < 4'd5) begin
                if (shifted[34:32] != 3'd0) begin
                    ovf_next = 1'b1;
                end
                if (phase_reg == PH_SEQ) begin
                    seq_next = seq_reg | shifted[31:0];
                end else begin
                    ack_next = ack_reg | shifted[31:0];
                end
            end else if (payload != 7'd0) begin
                ovf_next = 1'b1;
            end
            vcnt_next = vcnt_reg + 4'd1;

            if ((data_byte & rhd_pkg::CONT_BIT) != 8'd0) begin
                if (vcnt_next >= rhd_pkg::VCNT_W'(rhd_pkg::MAX_VARINT_BYTES)) begin
                    fin        = 1'b1;
                    fin_status = rhd_pkg::STATUS_TOO_LONG;
                end else if (frame_last) begin
                    fin        = 1'b1;
                    fin_status = rhd_pkg::STATUS_TRUNC;
                end
            end else if (ovf_next) begin
                fin        = 1'b1;
                fin_status = rhd_pkg::STATUS_OVERFLOW;
            end else if (phase_reg == PH_SEQ &&
                         (flags_reg & rhd_pkg::ACK_FLAG) != 8'd0) begin
                phase_next = PH_ACK;
                vcnt_next  = '0;
                ovf_next   = 1'b0;
                if (frame_last) begin
                    fin        = 1'b1;
                    fin_status = rhd_pkg::STATUS_TRUNC;
                end
            end else begin
                fin = 1'b1;
            end
        end

        if (fin) begin
            phase_next = PH_IDLE;
        end
    end

    always_comb begin
        out_flags = flags_next;
        if (cmp_next) begin
            out_flags = flags_next & ~(rhd_pkg::SEQ_FLAG | rhd_pkg::ACK_FLAG);
        end
        res_valid         = beat_fire && fin;
        res.status        = fin_status;
        res.header_flags  = out_flags;
        res.sequence_res  = (fin_status == rhd_pkg::STATUS_OK) ? seq_next : 32'd0;
        res.acknowledge   = (fin_status == rhd_pkg::STATUS_OK) ? ack_next : 32'd0;
        res.header_length = taken_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            flags_reg <= '0;
            seq_reg   <= '0;
            ack_reg   <= '0;
            vcnt_reg  <= '0;
            ovf_reg   <= 1'b0;
            taken_reg <= '0;
            cmp_reg   <= 1'b0;
        end else if (beat_fire) begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            seq_reg   <= seq_next;
            ack_reg   <= ack_next;
            vcnt_reg  <= vcnt_next;
            ovf_reg   <= ovf_next;
            taken_reg <= taken_next;
            cmp_reg   <= cmp_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/rhd_out_reg.sv
// Result register with stall handling toward the output stream.
`default_nettype none

module rhd_out_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire rhd_pkg::result_t    res_in,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output rhd_pkg::result_t         res_out,
    output logic                     can_accept
);

    logic              valid_reg;
    rhd_pkg::result_t  res_reg;

    // free slot, or the held beat leaves this cycle
    assign can_accept = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// File: sv/reliable_header_decoder_top.sv
// Top level of the reliable header decoder: stream ports, decode core, result register.
// A result beat appears on m_* in the cycle after the input beat that ends the header is accepted.
// Throughput: one input beat per cycle while s_tready is high; each byte is decoded by the core's
//   single pass of shift-or and flag logic between its state registers and the result register.
// Input stalls only while a finished result is held and m_tready is low.
// Reset: aresetn synchronous, active low; clears decode state to idle and drops m_tvalid.
`default_nettype none
`include "reliable_header_decoder_top_macros.svh"

module reliable_header_decoder_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream, one header byte per beat
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tlast,   // frame_last
    input  wire logic [1:0]   s_tuser,   // [0] header_start, [1] compact_mode
    // result stream, one beat per finished header
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [79:0]       m_tdata,   // [7:0] header_flags, [39:8] sequence_res,
                                         // [71:40] acknowledge, [76:72] header_length,
                                         // [79:77] zero
    output logic [1:0]        m_tuser    // [1:0] status
);

    logic              s_fire;
    logic              res_valid;
    rhd_pkg::result_t  res_core;
    rhd_pkg::result_t  res_held;

    assign s_fire = s_tvalid && s_tready;

    // Decode core: state advances only on accepted beats.
    rhd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_fire    (s_fire),
        .data_byte    (s_tdata),
        .header_start (s_tuser[0]),
        .frame_last   (s_tlast),
        .compact_mode (s_tuser[1]),
        .res_valid    (res_valid),
        .res          (res_core)
    );

    // Result register; frees in the same cycle the held beat is taken.
    rhd_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_valid),
        .res_in     (res_core),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .res_out    (res_held),
        .can_accept (s_tready)
    );

    assign m_tuser = res_held.status;
    assign m_tdata = {3'b000, res_held.header_length, res_held.acknowledge,
                      res_held.sequence_res, res_held.header_flags};

    // A start byte that is also the frame's last byte always ends its header.
    `RHD_ASSERT_NEXT(a_start_last_result, aclk, aresetn,
        s_fire && s_tuser[0] && s_tlast, m_tvalid,
        "start byte with frame end gave no result")

    // Errors never report decoded numbers.
    `RHD_ASSERT_NOW(a_err_zero_values, aclk, aresetn,
        m_tvalid && (m_tuser != rhd_pkg::STATUS_OK), m_tdata[71:8] == 64'd0,
        "error result carries nonzero sequence or ack")

    // Header length counts at least the flags byte and at most 21 bytes.
    `RHD_ASSERT_NOW(a_len_range, aclk, aresetn,
        m_tvalid, (m_tdata[76:72] != 5'd0) && (m_tdata[76:72] <= 5'd21),
        "header length out of range")

endmodule

`default_nettype wire

// File: tb/tb_reliable_header_decoder_top.sv
// Self-checking stream testbench for the reliable header decoder top level.
`default_nettype none

module tb_reliable_header_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1400;
    localparam int CALM_BYTES   = 150;    // tail of the run with no idling
    localparam int DRAIN_CYCLES = 8;      // result register holds one result

    // one input beat plus an optional hand-typed result
    typedef struct {
        logic [7:0]       data;
        logic             start;
        logic             last;
        logic             cmode;
        logic             has_want;
        rhd_pkg::result_t want;
    } hdr_beat_t;

    typedef enum logic [1:0] {PH_IDLE, PH_FIXED, PH_SEQ, PH_ACK} dec_phase_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;
    logic         s_tlast  = 1'b0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [79:0]  m_tdata;
    logic [1:0]   m_tuser;

    reliable_header_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder state as seen by the predictor
    dec_phase_t  st_phase   = PH_IDLE;
    logic [7:0]  st_flags   = '0;
    logic [31:0] st_seq     = '0;
    logic [31:0] st_ack     = '0;
    logic [3:0]  st_vcnt    = '0;
    logic        st_ovf     = 1'b0;
    logic [4:0]  st_len     = '0;
    logic        st_compact = 1'b0;

    rhd_pkg::result_t headers_due[$];  // decoded headers still to come out
    hdr_beat_t pending[$];             // beats queued for the sender
    int        fail_count    = 0;
    int        decoded_bytes = 0;      // beats the decoder actually consumed
    int        tx_pct        = 0;      // sender idle chance per beat, percent
    bit        calm          = 1'b0;

    function automatic rhd_pkg::result_t close_header(input rhd_pkg::status_t s);
        rhd_pkg::result_t r;
        r.status        = s;
        r.header_flags  = st_compact ? (st_flags & ~(rhd_pkg::SEQ_FLAG | rhd_pkg::ACK_FLAG))
                                     : st_flags;
        r.sequence_res  = (s == rhd_pkg::STATUS_OK) ? st_seq : 32'd0;
        r.acknowledge   = (s == rhd_pkg::STATUS_OK) ? st_ack : 32'd0;
        r.header_length = st_len;
        st_phase = PH_IDLE;
        return r;
    endfunction

    // Advance the decoder by one byte; returns 1 when a header finishes.
    function automatic bit decode_header_byte(input hdr_beat_t bt,
                                              output rhd_pkg::result_t r);
        logic [2:0]  idx;
        logic [63:0] shifted;
        r = '0;
        if (bt.start) begin
            st_flags   = bt.data;
            st_seq     = '0;
            st_ack     = '0;
            st_vcnt    = '0;
            st_ovf     = 1'b0;
            st_len     = 5'd1;
            st_compact = bt.cmode;
            if (!st_compact) begin
                st_phase = PH_FIXED;
            end else if ((bt.data & rhd_pkg::SEQ_FLAG) != 0) begin
                st_phase = PH_SEQ;
            end else if ((bt.data & rhd_pkg::ACK_FLAG) != 0) begin
                st_phase = PH_ACK;
            end else begin
                r = close_header(rhd_pkg::STATUS_OK);
                return 1'b1;
            end
            if (bt.last) begin
                r = close_header(rhd_pkg::STATUS_TRUNC);
                return 1'b1;
            end
            return 1'b0;
        end
        if (st_phase == PH_IDLE) return 1'b0;
        st_len = st_len + 5'd1;

        // fixed form: four sequence bytes then four ack bytes, LSB first
        if (st_phase == PH_FIXED) begin
            idx = 3'(st_len - 5'd2);
            if (idx < 4) st_seq |= 32'(bt.data) << (8 * idx);
            else         st_ack |= 32'(bt.data) << (8 * (idx - 4));
            if (st_len >= 5'd9) begin
                r = close_header(rhd_pkg::STATUS_OK);
                return 1'b1;
            end
            if (bt.last) begin
                r = close_header(rhd_pkg::STATUS_TRUNC);
                return 1'b1;
            end
            return 1'b0;
        end

        // compact form: 7 payload bits per byte, anything past bit 31 is overflow
        if (st_vcnt < 5) begin
            shifted = 64'(bt.data[6:0]) << (7 * st_vcnt);
            if (shifted[63:32] != 0) st_ovf = 1'b1;
            if (st_phase == PH_SEQ) st_seq |= shifted[31:0];
            else                    st_ack |= shifted[31:0];
        end else if (bt.data[6:0] != 0) begin
            st_ovf = 1'b1;
        end
        st_vcnt = st_vcnt + 4'd1;

        if ((bt.data & rhd_pkg::CONT_BIT) != 0) begin
            if (st_vcnt >= rhd_pkg::MAX_VARINT_BYTES) begin
                r = close_header(rhd_pkg::STATUS_TOO_LONG);
                return 1'b1;
            end
            if (bt.last) begin
                r = close_header(rhd_pkg::STATUS_TRUNC);
                return 1'b1;
            end
            return 1'b0;
        end
        if (st_ovf) begin
            r = close_header(rhd_pkg::STATUS_OVERFLOW);
            return 1'b1;
        end
        if (st_phase == PH_SEQ && (st_flags & rhd_pkg::ACK_FLAG) != 0) begin
            st_phase = PH_ACK;
            st_vcnt  = '0;
            st_ovf   = 1'b0;
            if (bt.last) begin
                r = close_header(rhd_pkg::STATUS_TRUNC);
                return 1'b1;
            end
            return 1'b0;
        end
        r = close_header(rhd_pkg::STATUS_OK);
        return 1'b1;
    endfunction

    function automatic void add_beat(logic [7:0] d, logic s, logic l, logic c);
        hdr_beat_t bt;
        bt.data     = d;
        bt.start    = s;
        bt.last     = l;
        bt.cmode    = c;
        bt.has_want = 1'b0;
        bt.want     = '0;
        pending = {pending, bt};
    endfunction

    // beat whose result is plain enough to type in; sequence and ack are zero
    function automatic void add_want(logic [7:0] d, logic s, logic l, logic c,
                                     rhd_pkg::status_t st, logic [7:0] fl,
                                     logic [4:0] len);
        add_beat(d, s, l, c);
        pending[$].has_want            = 1'b1;
        pending[$].want.status         = st;
        pending[$].want.header_flags   = fl;
        pending[$].want.header_length  = len;
    endfunction

    // One ULEB128 field: mostly minimal, some padded, some too wide or too long.
    function automatic void emit_varint();
        logic [63:0] value;
        logic [63:0] rest;
        int          style;
        int          minimal;
        int          total;
        style = $urandom_range(0, 99);
        if (style < 12) value = {$urandom, $urandom} >> $urandom_range(0, 31);
        else            value = 64'($urandom) >> $urandom_range(0, 32);
        minimal = 1;
        rest = value >> 7;
        while (rest != 0) begin
            minimal++;
            rest = rest >> 7;
        end
        total = minimal;
        if (style >= 12 && style < 30 && minimal < rhd_pkg::MAX_VARINT_BYTES) begin
            total = $urandom_range(minimal + 1, rhd_pkg::MAX_VARINT_BYTES);
        end else if (style >= 30 && style < 36) begin
            total = $urandom_range(rhd_pkg::MAX_VARINT_BYTES + 1,
                                   rhd_pkg::MAX_VARINT_BYTES + 3);
        end
        for (int k = 0; k < total; k++) begin
            add_beat({1'(k < total - 1), value[6:0]}, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
            value = value >> 7;
        end
    endfunction

    // One header with random content; some are cut short by frame end,
    // some abandoned for a restart, some trailed by stray bytes.
    function automatic void gen_header();
        logic [7:0] flags;
        logic       cm;
        int         kind;
        int         cut;
        flags = 8'($urandom);
        cm    = ($urandom_range(0, 2) != 0);
        kind  = $urandom_range(0, 99);
        add_beat(flags, 1'b1, 1'b0, cm);
        if (!cm) begin
            repeat (8) add_beat(8'($urandom), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        end else begin
            if ((flags & rhd_pkg::SEQ_FLAG) != 0) emit_varint();
            if ((flags & rhd_pkg::ACK_FLAG) != 0) emit_varint();
        end
        if ($urandom_range(0, 3) == 0) pending[$].last = 1'b1;
        if (kind < 14) begin
            cut = $urandom_range(0, pending.size() - 1);
            while (pending.size() > cut + 1) void'(pending.pop_back());
            pending[$].last = 1'b1;
        end else if (kind < 20) begin
            cut = $urandom_range(0, pending.size() - 1);
            while (pending.size() > cut + 1) void'(pending.pop_back());
            pending[$].last = 1'b0;
        end
        if (kind >= 92) begin
            repeat ($urandom_range(1, 3)) begin
                add_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end
        end
    endfunction

    task automatic send_beat(input hdr_beat_t bt);
        rhd_pkg::result_t r;
        bit               fired;
        if (!calm && $urandom_range(0, 99) < tx_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bt.data;
        s_tlast  <= bt.last;
        s_tuser  <= {bt.cmode, bt.start};
        do @(posedge aclk); while (!s_tready);
        if (bt.start || st_phase != PH_IDLE) decoded_bytes++;
        fired = decode_header_byte(bt, r);
        if (bt.has_want)  headers_due = {headers_due, bt.want};
        else if (fired)   headers_due = {headers_due, r};
    endtask

    task automatic send_pending();
        foreach (pending[i]) send_beat(pending[i]);
        pending.delete();
    endtask

    // sender holds off until the decoder has handed back everything
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (headers_due.size() != 0) @(posedge aclk);
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, what);
    endtask

    // result side: stall bursts, with calmer and busier stretches
    initial begin
        int hold;
        int rx_pct;
        int cyc;
        hold   = 0;
        rx_pct = 0;
        cyc    = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: rx_pct = 0;
                    1: rx_pct = 10;
                    default: rx_pct = 35;
                endcase
            end
            if (calm) begin
                m_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_pct) begin
                hold = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        rhd_pkg::result_t want;
        rhd_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status        = rhd_pkg::status_t'(m_tuser);
            got.header_flags  = m_tdata[7:0];
            got.sequence_res  = m_tdata[39:8];
            got.acknowledge   = m_tdata[71:40];
            got.header_length = m_tdata[76:72];
            if (headers_due.size() == 0) begin
                note_failure("result beat with no header pending");
            end else begin
                want = headers_due.pop_front();
                if (got.status !== want.status
                        || got.header_flags !== want.header_flags
                        || got.sequence_res !== want.sequence_res
                        || got.acknowledge !== want.acknowledge
                        || got.header_length !== want.header_length
                        || m_tdata[79:77] !== 3'b000) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: mismatch exp st=%0d fl=%h seq=%h ack=%h len=%0d",
                                 $realtime, want.status, want.header_flags,
                                 want.sequence_res, want.acknowledge, want.header_length);
                        $display("          got st=%0d fl=%h seq=%h ack=%h len=%0d pad=%b",
                                 got.status, got.header_flags, got.sequence_res,
                                 got.acknowledge, got.header_length, m_tdata[79:77]);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows
        add_beat(8'hFF, 1'b0, 1'b1, 1'b1);                          // stray byte while idle
        add_want(8'hF3, 1'b1, 1'b1, 1'b1, rhd_pkg::STATUS_OK,
                 8'hF3, 5'd1);                                      // compact, no fields
        add_want(8'hFF, 1'b1, 1'b1, 1'b0, rhd_pkg::STATUS_TRUNC,
                 8'hFF, 5'd1);                                      // fixed, frame ends at flags
        add_beat(8'h5A, 1'b1, 1'b0, 1'b0);                          // fixed header...
        add_beat(8'h11, 1'b0, 1'b0, 1'b1);
        add_beat(8'h22, 1'b0, 1'b0, 1'b0);                          // ...abandoned by restart
        add_beat(8'h04, 1'b1, 1'b0, 1'b1);                          // compact, sequence only
        repeat (9) add_beat(8'h80, 1'b0, 1'b0, 1'b0);
        add_want(8'h80, 1'b0, 1'b1, 1'b0, rhd_pkg::STATUS_TOO_LONG,
                 8'h00, 5'd11);                                     // too long beats frame end
        add_beat(8'h0C, 1'b1, 1'b0, 1'b1);                          // compact, both fields
        repeat (4) add_beat(8'hFF, 1'b0, 1'b0, 1'b1);
        add_want(8'h1F, 1'b0, 1'b0, 1'b1, rhd_pkg::STATUS_OVERFLOW,
                 8'h00, 5'd6);                                      // bit 32 set in sequence
        add_beat(8'h08, 1'b1, 1'b0, 1'b1);                          // compact, ack only
        add_beat(8'h81, 1'b0, 1'b0, 1'b0);                          // padded encoding of 1
        add_beat(8'h80, 1'b0, 1'b0, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1, 1'b0);                          // completes despite tlast
        send_pending();
        drain_results();

        // random headers
        decoded_bytes = 0;
        while (decoded_bytes < RANDOM_BYTES) begin
            if (decoded_bytes >= RANDOM_BYTES / 2 && decoded_bytes < RANDOM_BYTES / 2 + 20) begin
                drain_results();
            end
            calm = (decoded_bytes >= RANDOM_BYTES - CALM_BYTES);
            case ($urandom_range(0, 2))
                0: tx_pct = 0;
                1: tx_pct = 8;
                default: tx_pct = 30;
            endcase
            gen_header();
            send_pending();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (headers_due.size() != 0) begin
            note_failure("headers never came out");
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/rhd_pkg.sv
sv/rhd_core.sv
sv/rhd_out_reg.sv
sv/reliable_header_decoder_top.sv
tb/tb_reliable_header_decoder_top.sv
